/* design/conv2d_valid_window_filter_defines.svh */
// Assertion macros shared by the convolution filter RTL.
`ifndef CONV2D_VALID_WINDOW_FILTER_DEFINES_SVH
`define CONV2D_VALID_WINDOW_FILTER_DEFINES_SVH

// Checks that post holds in the same cycle whenever pre holds.
`define CVWF_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that post holds in the cycle after pre holds.
`define CVWF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* design/cvwf_pkg.sv */
// Package of constants and types for the 2D convolution window filter.
`timescale 1ns / 1ps
`default_nettype none

package cvwf_pkg;

    // Default geometry and coefficient format.
    localparam int DEF_WIN_ROWS       = 3;
    localparam int DEF_WIN_COLS       = 3;
    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_COEF_FRAC_BITS = 12;

    // Fixed field widths.
    localparam int PIX_W        = 8;
    localparam int COEF_W       = 16;
    localparam int COEF_IDX_W   = 4;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int MAX_HEIGHT   = 4096;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_W     = 13;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    // Register reset values.
    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    // Item function codes.
    localparam logic FUNC_COEF  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Position flags carried down the pipeline with each result.
    typedef struct packed {
        logic row_end;
        logic frame_end;
    } pos_flags_t;

endpackage

`default_nettype wire

/* design/cvwf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cvwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port: returns the contents before a write at the same edge.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/conv2d_valid_window_filter.sv */
// Top level of the streaming 2D convolution filter over the valid window region.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_valid_window_filter_defines.svh"

// The block filters 8-bit grayscale pixels arriving in raster order with a
// WIN_ROWS x WIN_COLS mask of signed coefficients, giving a result only for
// pixels that complete a full window. It takes one word per clock, coefficient
// writes and pixels alike, unless it stalls its input. A result passes the line
// store read, the products and the sum, one register stage each, and then the
// output register. Each pixel reads the line store RAM at acceptance and writes
// it back as it leaves stage 1; a read that meets the write of the previous
// pixel at the same column is forwarded. After reset the block clears all
// MAX_WIDTH columns of the line store, one column per cycle, and stalls its input
// meanwhile; configuration writes are taken at any time. Coefficients must be
// written before the first result that uses them.
module conv2d_valid_window_filter
    import cvwf_pkg::*;
#(
    parameter int WIN_ROWS       = DEF_WIN_ROWS,
    parameter int WIN_COLS       = DEF_WIN_COLS,
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel.
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         func,
    input  logic [PIX_W-1:0]             pixel_in,
    input  logic [COEF_IDX_W-1:0]        coef_index,
    input  logic signed [COEF_W-1:0]     coef_value,
    // Result channel.
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [PIX_W-1:0]             pixel_out,
    output logic                         row_end,
    output logic                         frame_end,
    output logic                         clipped,
    // Configuration channel.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int TAPS   = WIN_ROWS * WIN_COLS;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int LS_W   = (WIN_ROWS > 1) ? PIX_W * (WIN_ROWS - 1) : PIX_W;
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int SUM_W  = PROD_W + $clog2(TAPS);
    localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'((1 << COEF_FRAC_BITS) - 1);
    localparam logic signed [SUM_W-1:0] PIX_MAX   = SUM_W'((1 << PIX_W) - 1);

    // Configuration registers.
    logic [CFG_WIDTH_W-1:0]  width_cfg_reg;
    logic [CFG_HEIGHT_W-1:0] height_cfg_reg;
    logic [WID_W-1:0]        width_eff;
    logic [HEIGHT_W-1:0]     height_eff;

    // Frame position and line store clearing.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             clear_reg;
    logic [COL_W-1:0] clr_addr_reg;
    logic             clr_last;

    // Handshake and stage control.
    logic accept;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic out_free;
    logic s1_adv;
    logic last_col;
    logic last_row;
    logic produce;

    // Stage 1: line store read data available, window update.
    logic                     s1_valid_reg;
    logic                     s1_pix_reg;
    logic                     s1_prod_reg;
    pos_flags_t               s1_flags_reg;
    logic [PIX_W-1:0]         s1_pixel_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic [COEF_IDX_W-1:0]    s1_cidx_reg;
    logic signed [COEF_W-1:0] s1_cval_reg;
    logic                     fwd_reg;
    logic [LS_W-1:0]          fwd_data_reg;

    // Line store RAM ports.
    logic             ls_wr_en;
    logic [COL_W-1:0] ls_wr_addr;
    logic [LS_W-1:0]  ls_wr_data;
    logic [LS_W-1:0]  ls_wr_word;
    logic             ls_rd_en;
    logic [LS_W-1:0]  ls_rd_data;
    logic [LS_W-1:0]  rd_word;

    // Window, coefficients and products.
    logic [PIX_W-1:0]         column   [WIN_ROWS];
    logic [PIX_W-1:0]         win_reg  [WIN_ROWS][WIN_COLS];
    logic [PIX_W-1:0]         win_next [WIN_ROWS][WIN_COLS];
    logic signed [COEF_W-1:0] coef_reg [TAPS];
    logic signed [PROD_W-1:0] prod_next [TAPS];

    // Stage 2: products.
    logic                     s2_valid_reg;
    pos_flags_t               s2_flags_reg;
    logic signed [PROD_W-1:0] prod_reg [TAPS];

    // Stage 3: sum.
    logic                     s3_valid_reg;
    pos_flags_t               s3_flags_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  adj;
    logic signed [SUM_W-1:0]  quo;
    logic [PIX_W-1:0]         sat_pix;
    logic                     sat_clip;

    // Output register.
    logic             result_valid_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             row_end_reg;
    logic             frame_end_reg;
    logic             clipped_reg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= RST_IMAGE_WIDTH;
            height_cfg_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Width and height saturated to their usable ranges.
    always_comb
    begin
        if (width_cfg_reg == '0)
            width_eff = WID_W'(1);
        else if (int'(width_cfg_reg) > MAX_WIDTH)
            width_eff = WID_W'(MAX_WIDTH);
        else
            width_eff = WID_W'(width_cfg_reg);

        if (height_cfg_reg == '0)
            height_eff = HEIGHT_W'(1);
        else if (int'(height_cfg_reg) > MAX_HEIGHT)
            height_eff = HEIGHT_W'(MAX_HEIGHT);
        else
            height_eff = HEIGHT_W'(height_cfg_reg);
    end

    // Pipeline flow: a stage moves when the one after it is free or moving.
    assign out_free   = !result_valid_reg || !result_stall;
    assign rdy3       = !s3_valid_reg || out_free;
    assign rdy2       = !s2_valid_reg || rdy3;
    assign rdy1       = !s1_valid_reg || rdy2;
    assign s1_adv     = s1_valid_reg && rdy2;
    assign item_stall = clear_reg || !rdy1;
    assign accept     = item_valid && !item_stall;

    // Position decode of the incoming pixel.
    assign col_inc  = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W + 1)'(1);
    assign last_col = (int'(col_reg) == int'(width_eff) - 1);
    assign last_row = (int'(row_reg) == int'(height_eff) - 1);
    assign produce  = (int'(row_reg) >= WIN_ROWS - 1) && (int'(col_reg) >= WIN_COLS - 1);

    // Column and row counters, advanced as each pixel is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept && (func == FUNC_PIXEL))
        begin
            if (int'(col_inc) >= int'(width_eff))
            begin
                col_reg <= '0;
                if (row_inc >= (ROW_W + 1)'(height_eff))
                    row_reg <= '0;
                else
                    row_reg <= row_inc[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    // Clearing pass over the line store after reset.
    assign clr_last = (int'(clr_addr_reg) == MAX_WIDTH - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            if (clr_last)
                clear_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
        end
    end

    // Stage 1 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rdy1)
            s1_valid_reg <= accept;
    end

    // Stage 1 payload, with forwarding of a same-column write-back.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg             <= (func == FUNC_PIXEL);
            s1_prod_reg            <= produce;
            s1_flags_reg.row_end   <= last_col;
            s1_flags_reg.frame_end <= last_col && last_row;
            s1_pixel_reg           <= pixel_in;
            s1_col_reg             <= col_reg;
            s1_cidx_reg            <= coef_index;
            s1_cval_reg            <= coef_value;
            fwd_reg                <= s1_adv && s1_pix_reg && (s1_col_reg == col_reg);
            fwd_data_reg           <= ls_wr_word;
        end
    end

    // Line store port selection: clearing pass or pixel write-back.
    assign ls_rd_en = accept && (func == FUNC_PIXEL);

    always_comb
    begin
        if (clear_reg)
        begin
            ls_wr_en   = 1'b1;
            ls_wr_addr = clr_addr_reg;
            ls_wr_data = '0;
        end
        else
        begin
            ls_wr_en   = s1_adv && s1_pix_reg;
            ls_wr_addr = s1_col_reg;
            ls_wr_data = ls_wr_word;
        end
    end

    cvwf_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_addr (ls_wr_addr),
        .wr_data (ls_wr_data),
        .rd_en   (ls_rd_en),
        .rd_addr (col_reg),
        .rd_data (ls_rd_data)
    );

    // New column, oldest row first, and the word written back to the line store.
    assign rd_word = fwd_reg ? fwd_data_reg : ls_rd_data;

    always_comb
    begin
        for (int mr = 0; mr < WIN_ROWS - 1; mr++)
            column[mr] = rd_word[mr*PIX_W +: PIX_W];
        column[WIN_ROWS-1] = s1_pixel_reg;
        ls_wr_word = '0;
        for (int mr = 0; mr < WIN_ROWS - 1; mr++)
            ls_wr_word[mr*PIX_W +: PIX_W] = column[mr+1];
    end

    // Window shifted left by one column with the new column on the right.
    always_comb
    begin
        for (int mr = 0; mr < WIN_ROWS; mr++)
        begin
            for (int mc = 0; mc < WIN_COLS - 1; mc++)
                win_next[mr][mc] = win_reg[mr][mc+1];
            win_next[mr][WIN_COLS-1] = column[mr];
        end
    end

    // One multiplier per tap on the updated window.
    always_comb
    begin
        for (int mr = 0; mr < WIN_ROWS; mr++)
            for (int mc = 0; mc < WIN_COLS; mc++)
                prod_next[mr*WIN_COLS+mc] = PROD_W'(coef_reg[mr*WIN_COLS+mc])
                    * PROD_W'($signed({1'b0, win_next[mr][mc]}));
    end

    // Window registers, reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int mr = 0; mr < WIN_ROWS; mr++)
                for (int mc = 0; mc < WIN_COLS; mc++)
                    win_reg[mr][mc] <= '0;
        end
        else if (s1_adv && s1_pix_reg)
        begin
            win_reg <= win_next;
        end
    end

    // Coefficient store, written in item order as a write leaves stage 1.
    always_ff @(posedge clk)
    begin
        if (s1_adv && !s1_pix_reg)
        begin
            for (int t = 0; t < TAPS; t++)
                if (int'(s1_cidx_reg) == t)
                    coef_reg[t] <= s1_cval_reg;
        end
    end

    // Stage 2: registered products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (rdy2)
            s2_valid_reg <= s1_valid_reg && s1_pix_reg && s1_prod_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            prod_reg     <= prod_next;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // Stage 3: sum of products.
    always_comb
    begin
        sum_next = '0;
        for (int t = 0; t < TAPS; t++)
            sum_next = sum_next + SUM_W'(prod_reg[t]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (rdy3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && rdy3)
        begin
            sum_reg      <= sum_next;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // Scale with truncation toward zero, then saturate to the pixel range.
    always_comb
    begin
        adj = sum_reg + (sum_reg[SUM_W-1] ? ROUND_ADD : '0);
        quo = adj >>> COEF_FRAC_BITS;
        if (quo[SUM_W-1])
        begin
            sat_pix  = '0;
            sat_clip = 1'b1;
        end
        else if (quo > PIX_MAX)
        begin
            sat_pix  = '1;
            sat_clip = 1'b1;
        end
        else
        begin
            sat_pix  = quo[PIX_W-1:0];
            sat_clip = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_free)
            result_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && out_free)
        begin
            pixel_out_reg <= sat_pix;
            row_end_reg   <= s3_flags_reg.row_end;
            frame_end_reg <= s3_flags_reg.frame_end;
            clipped_reg   <= sat_clip;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign row_end      = row_end_reg;
    assign frame_end    = frame_end_reg;
    assign clipped      = clipped_reg;

    // Assertions.
    `CVWF_ASSERT_NOW(a_no_accept_in_clear, clear_reg, !accept, "word accepted during clear")
    `CVWF_ASSERT_NEXT(a_clear_ends, clear_reg && clr_last, !clear_reg, "line store clear did not end")
    `CVWF_ASSERT_NOW(a_col_in_range, !clear_reg, int'(col_reg) < MAX_WIDTH, "column beyond line store")
    `CVWF_ASSERT_NOW(a_result_source, $rose(result_valid_reg), $past(s3_valid_reg), "stray result")

endmodule

`default_nettype wire

/* tb/sv/conv2d_valid_window_filter_tb.sv */
// Self-checking testbench for the streaming 2D convolution window filter.
`timescale 1ns / 1ps

module conv2d_valid_window_filter_tb;
    import cvwf_pkg::*;

    localparam int MROWS        = DEF_WIN_ROWS;
    localparam int MCOLS        = DEF_WIN_COLS;
    localparam int MAXW         = DEF_MAX_WIDTH;
    localparam int FRAC         = DEF_COEF_FRAC_BITS;
    localparam int NTAPS        = MROWS * MCOLS;
    localparam int TOTAL_WORDS  = 1750;
    localparam int QUIET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 1000000;

    // One input word and one filtered result word.
    typedef struct {
        logic                    func;
        logic [PIX_W-1:0]        pix;
        logic [COEF_IDX_W-1:0]   tap_idx;
        logic signed [COEF_W-1:0] tap_val;
    } in_word_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             row_end;
        logic             frame_end;
        logic             clipped;
    } out_word_t;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_kind_t;
    typedef enum int {TAPS_FULL, TAPS_SMALL, TAPS_SMOOTH, TAPS_EDGE} tap_mode_t;
    typedef enum int {PH_REGULAR, PH_NARROW, PH_SHORT, PH_WIDE_SAT, PH_TALL, PH_CARRY} phase_kind_t;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    logic                     func         = FUNC_COEF;
    logic [PIX_W-1:0]         pixel_in     = '0;
    logic [COEF_IDX_W-1:0]    coef_index   = '0;
    logic signed [COEF_W-1:0] coef_value   = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [PIX_W-1:0]         pixel_out;
    logic                     row_end;
    logic                     frame_end;
    logic                     clipped;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index    = '0;
    logic [CFG_DATA_W-1:0]    cfg_data     = '0;

    // Words waiting for the driver and results waiting for the monitor.
    in_word_t  pending_words[$];
    out_word_t awaited_pixels[$];
    in_word_t  cur_word;
    out_word_t want;
    int        words_queued = 0;
    int        words_taken  = 0;
    int        item_total   = 0;
    int        mismatches   = 0;
    int        burst_left   = 1;
    int        gap_left     = 0;
    int        stall_left   = 0;
    int        cycle_count;
    stall_kind_t stall_kind = STALL_NONE;

    // Filter state as the block should hold it.
    logic [CFG_WIDTH_W-1:0]   width_reg;
    logic [CFG_HEIGHT_W-1:0]  height_reg;
    logic [PIX_W-1:0]         held_rows [MROWS-1][MAXW];
    logic [PIX_W-1:0]         win [MROWS][MCOLS];
    logic signed [COEF_W-1:0] taps [NTAPS];
    int unsigned              col_pos;
    int unsigned              row_pos;

    conv2d_valid_window_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .pixel_in     (pixel_in),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_out    (pixel_out),
        .row_end      (row_end),
        .frame_end    (frame_end),
        .clipped      (clipped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Updates the filter state for one accepted word and queues any result it gives.
    task automatic convolve_word(input in_word_t w);
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      c;
        int unsigned      nxt;
        logic [PIX_W-1:0] column [MROWS];
        longint           acc;
        longint           q;
        out_word_t        res;
        w_eff = (width_reg < 1) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
        h_eff = (height_reg < 1) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        if (w.func == FUNC_COEF)
        begin
            // Indexes beyond the mask are dropped.
            if (w.tap_idx < NTAPS)
                taps[w.tap_idx] = w.tap_val;
        end
        else
        begin
            c = (col_pos >= MAXW) ? MAXW - 1 : col_pos;
            // New column, oldest row first; the line store moves up by one row.
            for (int mr = 0; mr < MROWS - 1; mr++)
                column[mr] = held_rows[mr][c];
            column[MROWS-1] = w.pix;
            for (int mr = 0; mr < MROWS - 1; mr++)
                held_rows[mr][c] = column[mr+1];
            for (int mr = 0; mr < MROWS; mr++)
            begin
                for (int mc = 0; mc < MCOLS - 1; mc++)
                    win[mr][mc] = win[mr][mc+1];
                win[mr][MCOLS-1] = column[mr];
            end
            // A result only once the window lies wholly inside the frame.
            if (row_pos >= MROWS - 1 && c >= MCOLS - 1)
            begin
                acc = 0;
                for (int mr = 0; mr < MROWS; mr++)
                    for (int mc = 0; mc < MCOLS; mc++)
                        acc += longint'(taps[mr*MCOLS+mc]) * longint'(win[mr][mc]);
                // Division on signed integers truncates toward zero.
                q = acc / (longint'(1) << FRAC);
                res.clipped   = (q < 0 || q > 255);
                res.pix       = (q < 0) ? 8'd0 : ((q > 255) ? 8'd255 : q[PIX_W-1:0]);
                res.row_end   = (c == w_eff - 1);
                res.frame_end = (c == w_eff - 1) && (row_pos == h_eff - 1);
                awaited_pixels.push_back(res);
            end
            nxt = col_pos + 1;
            if (nxt >= w_eff)
            begin
                nxt = 0;
                row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
            end
            col_pos = nxt;
        end
    endtask

    task automatic push_pixel(input int p);
        in_word_t w;
        w.func    = FUNC_PIXEL;
        w.pix     = p[PIX_W-1:0];
        w.tap_idx = COEF_IDX_W'($urandom);
        w.tap_val = COEF_W'($urandom);
        pending_words.push_back(w);
        words_queued++;
        item_total++;
    endtask

    task automatic push_tap(input int idx, input logic signed [COEF_W-1:0] val);
        in_word_t w;
        w.func    = FUNC_COEF;
        w.pix     = PIX_W'($urandom);
        w.tap_idx = idx[COEF_IDX_W-1:0];
        w.tap_val = val;
        pending_words.push_back(w);
        words_queued++;
        if (idx < NTAPS)
            item_total++;
    endtask

    function automatic logic signed [COEF_W-1:0] random_tap(input tap_mode_t m);
        int v;
        case (m)
            TAPS_FULL:   v = $urandom;
            TAPS_SMALL:  v = int'($urandom_range(0, 64)) - 32;
            TAPS_SMOOTH: v = $urandom_range(0, 1200);
            default:     v = int'($urandom_range(0, 3000)) - 1500;
        endcase
        return v[COEF_W-1:0];
    endfunction

    // Waits until every word is taken and every result has come back, then a
    // little longer for coefficient words still in the pipeline.
    task automatic wait_quiet();
        while (words_taken != words_queued || awaited_pixels.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = data[CFG_WIDTH_W-1:0];
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = data[CFG_HEIGHT_W-1:0];
        @(posedge clk);
    endtask

    // Input driver: bursts of words separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                convolve_word(cur_word);
                words_taken++;
            end
            if (!(item_valid && item_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word = pending_words.pop_front();
                    func       <= cur_word.func;
                    pixel_in   <= cur_word.pix;
                    coef_index <= cur_word.tap_idx;
                    coef_value <= cur_word.tap_val;
                    item_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        if ($urandom_range(0, 15) == 0)
                            gap_left = $urandom_range(10, 30);
                        else if ($urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 6);
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_pixels.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = awaited_pixels.pop_front();
                    if (pixel_out !== want.pix)
                        report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                                  pixel_out, want.pix));
                    if (row_end !== want.row_end)
                        report_mismatch($sformatf("row_end %b, expected %b",
                                                  row_end, want.row_end));
                    if (frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  frame_end, want.frame_end));
                    if (clipped !== want.clipped)
                        report_mismatch($sformatf("clipped %b, expected %b",
                                                  clipped, want.clipped));
                end
            end
            if (stall_left == 0)
            begin
                stall_kind = stall_kind_t'($urandom_range(STALL_NONE, STALL_HEAVY));
                stall_left = $urandom_range(40, 400);
            end
            else
            begin
                stall_left--;
            end
            case (stall_kind)
                STALL_NONE:     result_stall <= 1'b0;
                STALL_RANDOM:   result_stall <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: result_stall <= (stall_left % 7) < 3;
                default:        result_stall <= (stall_left % 32) < 20;
            endcase
        end
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus: directed words, one wide frame, then random phases.
    initial
    begin
        int          n;
        int          w_cfg;
        int          h_cfg;
        int          pick;
        phase_kind_t kind;
        tap_mode_t   mode;
        width_reg  = RST_IMAGE_WIDTH;
        height_reg = RST_IMAGE_HEIGHT;
        col_pos    = 0;
        row_pos    = 0;
        for (int mr = 0; mr < MROWS; mr++)
            for (int mc = 0; mc < MCOLS; mc++)
                win[mr][mc] = '0;
        for (int mr = 0; mr < MROWS - 1; mr++)
            for (int x = 0; x < MAXW; x++)
                held_rows[mr][x] = '0;
        for (int k = 0; k < NTAPS; k++)
            taps[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame, extreme taps, and writes past the end of the mask.
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MCOLS));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MROWS));
        for (int k = 0; k < NTAPS; k++)
            push_tap(k, (k == 0) ? 16'sh8000 : (k == NTAPS - 1) ? 16'sh7FFF :
                        (k == NTAPS / 2) ? (16'sd1 <<< FRAC) : 16'sd0);
        push_tap(NTAPS, 16'sh5A5A);
        push_tap((1 << COEF_IDX_W) - 1, 16'shA5A5);
        for (int k = 0; k < NTAPS; k++)
            push_pixel((k % 2 == 0) ? 255 : 0);
        push_pixel(0);
        push_pixel(128);
        push_pixel(255);

        // A wide row, run to the end of its frame so much of the line store is used.
        wait_quiet();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MAXW / 2));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MROWS));
        for (int k = 0; k < NTAPS; k++)
            push_tap(k, random_tap(TAPS_SMOOTH));
        n = (MROWS - row_pos) * (MAXW / 2) - col_pos;
        for (int i = 0; i < n; i++)
            push_pixel($urandom_range(0, 255));

        while (item_total < TOTAL_WORDS)
        begin
            wait_quiet();
            pick = $urandom_range(0, 9);
            kind = (pick < 5) ? PH_REGULAR : phase_kind_t'(pick - 4);
            case (kind)
                PH_NARROW:
                begin
                    // Rows narrower than the mask: counters wrap, nothing comes out.
                    w_cfg = $urandom_range(0, MCOLS - 1);
                    h_cfg = $urandom_range(MROWS, 8);
                    n     = $urandom_range(20, 60);
                end
                PH_SHORT:
                begin
                    w_cfg = $urandom_range(MCOLS, 10);
                    h_cfg = $urandom_range(0, MROWS - 1);
                    n     = $urandom_range(20, 60);
                end
                PH_WIDE_SAT:
                begin
                    w_cfg = ($urandom_range(0, 3) == 0) ? 0 :
                            $urandom_range(MAXW + 1, (1 << CFG_DATA_W) - 1);
                    h_cfg = $urandom_range(MROWS, 5);
                    n     = $urandom_range(60, 150);
                end
                PH_TALL:
                begin
                    w_cfg = $urandom_range(MCOLS, 6);
                    h_cfg = ($urandom_range(0, 1) == 0) ? MAX_HEIGHT :
                            $urandom_range(MAX_HEIGHT + 1, (1 << CFG_HEIGHT_W) - 1);
                    n     = $urandom_range(60, 200);
                end
                PH_CARRY:
                begin
                    // Settings kept, counters carry on from wherever they stopped.
                    w_cfg = int'(width_reg);
                    h_cfg = int'(height_reg);
                    n     = $urandom_range(30, 120);
                end
                default:
                begin
                    w_cfg = $urandom_range(MCOLS, 12);
                    h_cfg = $urandom_range(MROWS, 8);
                    n     = w_cfg * h_cfg * $urandom_range(1, 3) +
                            $urandom_range(0, w_cfg * h_cfg - 1);
                end
            endcase
            if (kind != PH_CARRY)
            begin
                write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_cfg));
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_cfg));
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_IMAGE_HEIGHT + 1, (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
            mode = tap_mode_t'($urandom_range(TAPS_FULL, TAPS_EDGE));
            if ($urandom_range(0, 1) == 0)
                for (int k = 0; k < NTAPS; k++)
                    push_tap(k, random_tap(mode));
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    push_tap($urandom_range(0, (1 << COEF_IDX_W) - 1), random_tap(mode));
                if ($urandom_range(0, 9) == 0)
                    push_pixel(($urandom_range(0, 1) == 0) ? 0 : 255);
                else
                    push_pixel($urandom_range(0, 255));
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
